>>> hdl/block_adpcm_decoder_assert.svh
// Assertion macros for the block ADPCM decoder.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef BLOCK_ADPCM_DECODER_ASSERT_SVH
`define BLOCK_ADPCM_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define BADPCM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BADPCM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BADPCM_ASSERT_IMP(lbl, ante, cons, msg)
`define BADPCM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/badpcm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the block ADPCM decoder.
// No dependencies.
package badpcm_pkg;

	localparam int CHAN_W = 4;
	localparam int SAMPLES_W = 11;

	localparam logic [1:0] MODE_TABLE = 2'd0;
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_EXP = 2'd2;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	localparam logic [2:0] REG_CODING_MODE = 3'd0;
	localparam logic [2:0] REG_COEF_FIRST = 3'd1;
	localparam logic [2:0] REG_COEF_SECOND = 3'd2;
	localparam logic [2:0] REG_SAMPLE_BITS = 3'd3;
	localparam logic [2:0] REG_BLOCK_BYTES = 3'd4;
	localparam logic [2:0] REG_CHANNEL_COUNT = 3'd5;

	localparam logic [3:0] CODE_MAX_BITS = 4'd8;
	localparam logic [7:0] BLOCK_MIN = 8'd3;
	localparam logic [12:0] SCALE_MASK = 13'h1fff;
	localparam logic [3:0] EXP_BASE = 4'd12;

	localparam logic [26:0] DIV3_MUL = 27'd10923;
	localparam logic [26:0] DIV5_MUL = 27'd6554;
	localparam logic [26:0] DIV7_MUL = 27'd9363;

	typedef struct packed {
		logic [1:0] coding_mode;
		logic signed [15:0] coef_first;
		logic signed [15:0] coef_second;
		logic [3:0] sample_bits;
		logic [7:0] block_bytes;
		logic [3:0] channel_count;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		coding_mode: MODE_LINEAR,
		coef_first: 16'sd0,
		coef_second: 16'sd0,
		sample_bits: 4'd4,
		block_bytes: 8'd18,
		channel_count: 4'd1
	};

	typedef struct packed {
		logic signed [15:0] c0;
		logic signed [15:0] c1;
	} coef_pair_t;

	// one request for the back end: a code to decode, or a history clear
	typedef struct packed {
		logic restart;
		logic signed [7:0] code;
		logic [12:0] scale;
		coef_pair_t coef;
		logic [CHAN_W-1:0] chan;
		logic last;
		logic bend;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic pos_zero;
	} front_stat_t;

	function automatic coef_pair_t fixed_pair(input logic [1:0] sel);
		coef_pair_t p;
		case (sel)
			2'd0: p = '{c0: 16'sd0, c1: 16'sd0};
			2'd1: p = '{c0: 16'sd3840, c1: 16'sd0};
			2'd2: p = '{c0: 16'sd7360, c1: -16'sd3328};
			2'd3: p = '{c0: 16'sd6272, c1: -16'sd3520};
			default: p = '{c0: 16'sd0, c1: 16'sd0};
		endcase
		return p;
	endfunction

	// body bits over code width, by reciprocal multiply for widths 3, 5, 6 and 7
	function automatic logic [SAMPLES_W-1:0] blk_samples(input logic [10:0] body,
			input logic [3:0] bits);
		logic [26:0] prod;
		logic [10:0] q;
		prod = '0;
		q = body;
		case (bits)
			4'd1: q = body;
			4'd2: q = body >> 1;
			4'd3: begin
				prod = 27'(body) * DIV3_MUL;
				q = prod[25:15];
			end
			4'd4: q = body >> 2;
			4'd5: begin
				prod = 27'(body) * DIV5_MUL;
				q = prod[25:15];
			end
			4'd6: begin
				prod = 27'(body >> 1) * DIV3_MUL;
				q = prod[25:15];
			end
			4'd7: begin
				prod = 27'(body) * DIV7_MUL;
				q = prod[26:16];
			end
			4'd8: q = body >> 3;
			default: q = body;
		endcase
		return q;
	endfunction

endpackage

>>> hdl/badpcm_queue.sv
`timescale 1ns / 1ps
// Small flop-based request queue between the front and back ends.
// No dependencies.
module badpcm_queue #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] wdata,
	output logic full,
	input logic pop,
	output logic valid,
	output logic [W-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[head_q];
	assign do_push = push && !full;
	assign do_pop = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
			end
			if (do_pop) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[tail_q] <= wdata;
		end
	end

endmodule

>>> hdl/badpcm_front.sv
`timescale 1ns / 1ps
// Front end: takes stream bytes, tracks block position and header, and splits body
// bytes into one code request a cycle while the queue has room. Depends on badpcm_pkg.
module badpcm_front #(
	parameter int MAX_CHANNELS = 8,
	parameter int MAX_BLOCK_BYTES = 255
) (
	input logic clk,
	input logic arst_n,
	input badpcm_pkg::cfg_t cfg,
	input logic push,
	input logic operation,
	input logic [7:0] data_byte,
	output logic full,
	output logic q_push,
	output badpcm_pkg::entry_t q_wdata,
	input logic q_full,
	output badpcm_pkg::front_stat_t stat
);
	import badpcm_pkg::*;

	logic [7:0] pos_q, hdr_hi_q;
	logic [CHAN_W-1:0] chan_q, ext_ch_q;
	logic [12:0] scale_q;
	logic [1:0] tsel_q;
	logic [15:0] buf_q;
	logic [3:0] cnt_q;
	logic [SAMPLES_W-1:0] left_q;
	logic busy_q, end_pend_q;

	logic [3:0] bits_eff;
	logic [7:0] blen;
	logic [4:0] chans_eff, chan_next;
	logic [10:0] body_bits;
	logic [SAMPLES_W-1:0] spb;
	logic accept, restart, blk_end, starts, ext_fire, more;
	logic [15:0] nbuf, shifted;
	logic [3:0] ncnt, cnt_nx;
	logic [SAMPLES_W-1:0] left_nx;
	logic [12:0] field, hdr_scale;
	logic [7:0] mask8, code_raw, code_s;
	logic sign_bit;
	coef_pair_t pair;

	always_comb begin
		bits_eff = cfg.sample_bits;
		if (cfg.sample_bits == 4'd0) begin
			bits_eff = 4'd1;
		end else if (cfg.sample_bits > CODE_MAX_BITS) begin
			bits_eff = CODE_MAX_BITS;
		end
		blen = (cfg.block_bytes < BLOCK_MIN) ? BLOCK_MIN : cfg.block_bytes;
		if (int'(blen) > MAX_BLOCK_BYTES) begin
			blen = 8'(MAX_BLOCK_BYTES);
		end
		chans_eff = {1'b0, cfg.channel_count};
		if (cfg.channel_count == 4'd0) begin
			chans_eff = 5'd1;
		end else if (int'(cfg.channel_count) > MAX_CHANNELS) begin
			chans_eff = 5'(MAX_CHANNELS);
		end
	end

	assign body_bits = {blen - 8'd2, 3'b000};
	assign spb = blk_samples(body_bits, bits_eff);
	assign chan_next = {1'b0, chan_q} + 5'd1;

	assign full = busy_q || q_full;
	assign accept = push && !full;
	assign restart = accept && (operation == OP_RESTART);
	assign blk_end = ({1'b0, pos_q} + 9'd1) >= {1'b0, blen};

	// header: low 13 bits are the scale (an exponent in exp mode), bits 14..13 pick the table pair
	assign field = {hdr_hi_q[4:0], data_byte} & SCALE_MASK;
	assign hdr_scale = (field > 13'(EXP_BASE)) ? 13'd0 : (13'd1 << (EXP_BASE - field[3:0]));

	assign nbuf = {buf_q[7:0], data_byte};
	assign ncnt = cnt_q + 4'd8;
	assign starts = (pos_q > 8'd1) && (left_q != '0) && (ncnt >= bits_eff);

	// code extraction, MSB first
	always_comb begin
		shifted = buf_q >> (cnt_q - bits_eff);
		mask8 = 8'hff >> (CODE_MAX_BITS - bits_eff);
		code_raw = shifted[7:0] & mask8;
		sign_bit = code_raw[3'(bits_eff - 4'd1)];
		code_s = sign_bit ? (code_raw | ~mask8) : code_raw;
		cnt_nx = cnt_q - bits_eff;
		left_nx = left_q - SAMPLES_W'(1);
		more = (cnt_nx >= bits_eff) && (left_nx != '0);
		if (cfg.coding_mode == MODE_TABLE) begin
			pair = fixed_pair(tsel_q);
		end else begin
			pair = '{c0: cfg.coef_first, c1: cfg.coef_second};
		end
	end

	assign ext_fire = busy_q && !q_full;
	assign q_push = ext_fire || restart;

	always_comb begin
		q_wdata = '0;
		if (busy_q) begin
			q_wdata.code = code_s;
			q_wdata.scale = scale_q;
			q_wdata.coef = pair;
			q_wdata.chan = ext_ch_q;
			q_wdata.last = !more;
			q_wdata.bend = (left_nx == '0);
		end else begin
			q_wdata.restart = 1'b1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.pos_zero = (pos_q == 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_hi_q <= '0;
			chan_q <= '0;
			ext_ch_q <= '0;
			scale_q <= '0;
			tsel_q <= '0;
			buf_q <= '0;
			cnt_q <= '0;
			left_q <= '0;
			busy_q <= 1'b0;
			end_pend_q <= 1'b0;
		end else if (restart) begin
			pos_q <= '0;
			hdr_hi_q <= '0;
			chan_q <= '0;
			scale_q <= '0;
			tsel_q <= '0;
			buf_q <= '0;
			cnt_q <= '0;
			left_q <= '0;
			busy_q <= 1'b0;
			end_pend_q <= 1'b0;
		end else if (accept) begin
			if (pos_q == 8'd0) begin
				hdr_hi_q <= data_byte;
			end else if (pos_q == 8'd1) begin
				tsel_q <= hdr_hi_q[6:5];
				scale_q <= (cfg.coding_mode == MODE_EXP) ? hdr_scale : field;
				buf_q <= '0;
				cnt_q <= '0;
				left_q <= spb;
			end else if (left_q != '0) begin
				buf_q <= nbuf;
				cnt_q <= ncnt;
				if (starts) begin
					busy_q <= 1'b1;
					ext_ch_q <= chan_q;
					end_pend_q <= blk_end;
				end
			end
			if (blk_end) begin
				chan_q <= (chan_next >= chans_eff) ? '0 : chan_next[CHAN_W-1:0];
				pos_q <= '0;
				// hold the bits until extraction of this byte finishes
				if (!starts) begin
					buf_q <= '0;
					cnt_q <= '0;
					left_q <= '0;
				end
			end else begin
				pos_q <= pos_q + 8'd1;
			end
		end else if (ext_fire) begin
			cnt_q <= cnt_nx;
			left_q <= left_nx;
			if (!more) begin
				busy_q <= 1'b0;
				if (end_pend_q) begin
					buf_q <= '0;
					cnt_q <= '0;
					left_q <= '0;
					end_pend_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> hdl/badpcm_back.sv
`timescale 1ns / 1ps
// Back end: per-channel history, two-tap prediction, scaling and saturation,
// plus the result register. Depends on badpcm_pkg.
module badpcm_back #(
	parameter int MAX_CHANNELS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input badpcm_pkg::entry_t q_rdata,
	output logic q_pop,
	output logic empty,
	input logic pop,
	output logic signed [15:0] sample,
	output logic [2:0] channel,
	output logic last_of_run,
	output logic block_end
);
	import badpcm_pkg::*;

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic signed [15:0] hist_new_q [MAX_CHANNELS];
	logic signed [15:0] hist_old_q [MAX_CHANNELS];

	logic s1_valid_q;
	logic signed [31:0] p0_s1, p1_s1;
	logic signed [21:0] dv_s1;
	logic [CHAN_W-1:0] ch_s1;
	logic last_s1, bend_s1;

	logic out_valid_q;
	logic signed [15:0] sample_q;
	logic [2:0] chan_q;
	logic last_q, bend_q;

	logic take, fire_b;
	logic [IDX_W-1:0] idx, idx_s1;
	logic signed [15:0] h0, h1;
	logic signed [31:0] p0, p1;
	logic signed [21:0] dv;
	logic signed [32:0] sum;
	logic signed [22:0] v;
	logic signed [15:0] v_sat;

	// one sample at a time: the next one may need this one's history
	assign take = q_valid && !s1_valid_q;
	assign q_pop = take;
	assign idx = q_rdata.chan[IDX_W-1:0];
	assign h0 = hist_new_q[idx];
	assign h1 = hist_old_q[idx];

	always_comb begin
		p0 = $signed({{16{q_rdata.coef.c0[15]}}, q_rdata.coef.c0}) * $signed({{16{h0[15]}}, h0});
		p1 = $signed({{16{q_rdata.coef.c1[15]}}, q_rdata.coef.c1}) * $signed({{16{h1[15]}}, h1});
		dv = $signed({{14{q_rdata.code[7]}}, q_rdata.code}) * $signed({9'b0, q_rdata.scale});
	end

	assign fire_b = s1_valid_q && (!out_valid_q || pop);
	assign idx_s1 = ch_s1[IDX_W-1:0];

	// floor shift of the prediction is an arithmetic drop of 12 bits
	always_comb begin
		sum = $signed({p0_s1[31], p0_s1}) + $signed({p1_s1[31], p1_s1});
		v = $signed({dv_s1[21], dv_s1}) + $signed({{2{sum[32]}}, sum[32:12]});
		if (v > 23'sd32767) begin
			v_sat = 16'sh7fff;
		end else if (v < -23'sd32768) begin
			v_sat = -16'sh8000;
		end else begin
			v_sat = v[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				hist_new_q[i] <= '0;
				hist_old_q[i] <= '0;
			end
		end else begin
			if (take) begin
				s1_valid_q <= !q_rdata.restart;
				if (q_rdata.restart) begin
					for (int i = 0; i < MAX_CHANNELS; i++) begin
						hist_new_q[i] <= '0;
						hist_old_q[i] <= '0;
					end
				end
			end else if (fire_b) begin
				s1_valid_q <= 1'b0;
				hist_new_q[idx_s1] <= v_sat;
				hist_old_q[idx_s1] <= hist_new_q[idx_s1];
			end
			if (fire_b) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			p0_s1 <= p0;
			p1_s1 <= p1;
			dv_s1 <= dv;
			ch_s1 <= q_rdata.chan;
			last_s1 <= q_rdata.last;
			bend_s1 <= q_rdata.bend;
		end
		if (fire_b) begin
			sample_q <= v_sat;
			chan_q <= ch_s1[2:0];
			last_q <= last_s1;
			bend_q <= bend_s1;
		end
	end

	assign empty = !out_valid_q;
	assign sample = sample_q;
	assign channel = chan_q;
	assign last_of_run = last_q;
	assign block_end = bend_q;

endmodule

>>> hdl/block_adpcm_decoder.sv
// Each code of an accepted byte goes through the front end, the request queue and the back
// end's stage-one register into the result register. The back end takes a new sample only
// once the last has left stage one (history loop: multiply, then add and saturate); the
// front end takes no new byte while splitting one. Header bytes and bytes past the last
// sample give no result. Reset (arst_n low, asynchronous) loads register defaults and clears
// all stream state and history at once; no clearing pass follows.
`timescale 1ns / 1ps
// Top level: configuration registers, front end, request queue and back end.
// Depends on badpcm_pkg, badpcm_front, badpcm_queue, badpcm_back and block_adpcm_decoder_assert.svh.
`include "block_adpcm_decoder_assert.svh"
module block_adpcm_decoder #(
	parameter int MAX_CHANNELS = 8,
	parameter int MAX_BLOCK_BYTES = 255,
	parameter int QUEUE_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic operation,
	input logic [7:0] data_byte,
	output logic full,
	output logic empty,
	input logic pop,
	output logic signed [15:0] sample,
	output logic [2:0] channel,
	output logic last_of_run,
	output logic block_end,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_addr,
	input logic [15:0] cfg_data
);
	import badpcm_pkg::*;

	cfg_t cfg_q;
	logic q_push, q_full, q_valid, q_pop;
	entry_t q_wdata, q_rdata;
	front_stat_t front_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_CODING_MODE: cfg_q.coding_mode <= cfg_data[1:0];
				REG_COEF_FIRST: cfg_q.coef_first <= cfg_data;
				REG_COEF_SECOND: cfg_q.coef_second <= cfg_data;
				REG_SAMPLE_BITS: cfg_q.sample_bits <= cfg_data[3:0];
				REG_BLOCK_BYTES: cfg_q.block_bytes <= cfg_data[7:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	badpcm_front #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.operation(operation),
		.data_byte(data_byte),
		.full(full),
		.q_push(q_push),
		.q_wdata(q_wdata),
		.q_full(q_full),
		.stat(front_stat)
	);

	badpcm_queue #(
		.W($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.valid(q_valid),
		.rdata(q_rdata)
	);

	badpcm_back #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_rdata(q_rdata),
		.q_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.sample(sample),
		.channel(channel),
		.last_of_run(last_of_run),
		.block_end(block_end)
	);

	`BADPCM_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full, "request pushed into a full queue")
	`BADPCM_ASSERT_IMP(a_block_end_last, !empty && block_end, last_of_run, "block end not last of run")
	`BADPCM_ASSERT_NXT(a_restart_rewinds, push && !full && operation == OP_RESTART, front_stat.pos_zero && !front_stat.busy, "restart did not rewind the block position")

endmodule
